/* src/sat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants for the summed-area table block
// Field widths, operation and status codes, register map, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int SUM_W      = 36;
	localparam int SAMPLE_W   = 24;
	localparam int COORD_W    = 16;
	localparam int GRID_W     = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS    = 64;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register select is the word address bit
	localparam logic REG_GRID_COLUMNS = 1'b0;
	localparam logic REG_GRID_ROWS    = 1'b1;

	typedef enum logic [1:0] {
		QS_OK        = 2'd0,
		QS_EMPTY     = 2'd1,
		QS_NOT_READY = 2'd2
	} qstat_t;

	typedef struct packed {
		logic accept;    // input beat taken this cycle
		logic ld_write;  // write prefix entry, advance load position
		logic rd_db;     // read corners D and B
		logic rd_ca;     // read corners C and A, capture D - B
		logic cap_ac;    // capture A - C
		logic out_load;  // load output register
	} cmd_t;

	typedef struct packed {
		logic load_skip; // load beat is ignored
		logic qstat_ok;  // captured query has a nonempty ready window
		logic out_busy;  // output register full and stalled
	} sts_t;

	// index width, at least one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

/* src/sat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram: generic RAM, one write port, two registered read ports
// Read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* src/sat_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ctrl: sequencer for loads and queries
// Takes one beat in IDLE, then steps the datapath through the table write of
// a live load, or through the four corner reads (ok queries only) and the output load.
// ----------------------------------------------------------------------------
module sat_ctrl
	import sat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LD_WR = 6'b000010,
		S_Q_RD1 = 6'b000100,
		S_Q_RD2 = 6'b001000,
		S_Q_SUM = 6'b010000,
		S_Q_OUT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_QUERY) begin
						state_d = S_Q_RD1;
					end else if (!sts.load_skip) begin
						state_d = S_LD_WR;
					end
				end
			end
			S_LD_WR: state_d = S_IDLE;
			S_Q_RD1: begin
				state_d = sts.qstat_ok ? S_Q_RD2 : S_Q_OUT;
			end
			S_Q_RD2: state_d = S_Q_SUM;
			S_Q_SUM: state_d = S_Q_OUT;
			S_Q_OUT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.ld_write = (state_q == S_LD_WR);
		cmd.rd_db    = (state_q == S_Q_RD1) && sts.qstat_ok;
		cmd.rd_ca    = (state_q == S_Q_RD2);
		cmd.cap_ac   = (state_q == S_Q_SUM);
		cmd.out_load = (state_q == S_Q_OUT) && !sts.out_busy;
	end

	// a live load always goes on to its table write
	a_load_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_LOAD && !sts.load_skip) |=> state_q == S_LD_WR)
		else $error("live load did not reach table write");

	// a finished result waits while the output register is held
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_OUT && sts.out_busy) |=> state_q == S_Q_OUT)
		else $error("result left while output was stalled");

endmodule

/* src/sat_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_datapath: grid registers, load position, prefix table and query math
// Row-major address {row, col}; corner entries on the zero edge are forced
// to zero in place of the read data.
// ----------------------------------------------------------------------------
module sat_datapath
	import sat_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	// input beat fields
	input  logic                      operation,
	input  logic                      new_grid,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic signed [COORD_W-1:0] col_low,
	input  logic signed [COORD_W-1:0] col_high,
	input  logic signed [COORD_W-1:0] row_low,
	input  logic signed [COORD_W-1:0] row_high,
	// result beat
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SUM_W-1:0]   window_sum,
	output logic [1:0]                query_status,
	// register access
	input  logic                      cfg_wr,
	input  logic                      cfg_sel,
	input  logic [GRID_W-1:0]         cfg_wdata,
	output logic [GRID_W-1:0]         cfg_rdata
);

	localparam int CW  = idx_w(MAX_COLUMNS);
	localparam int RW  = idx_w(MAX_ROWS);
	localparam int AW  = CW + RW;
	localparam int ECW = $clog2(MAX_COLUMNS + 1);
	localparam int ERW = $clog2(MAX_ROWS + 1);
	localparam int CRD = COORD_W + 1;

	logic [GRID_W-1:0] grid_columns_q, grid_rows_q;
	logic [SUM_W-1:0]  rsum_q;
	logic [CW-1:0]     load_col_q;
	logic [RW-1:0]     load_row_q;
	logic              complete_q;

	logic [CW-1:0]     cl_q, ch_q;
	logic [RW-1:0]     rl_q, rh_q;
	qstat_t            qstat_q;
	logic [SUM_W-1:0]  db_q, ac_q;

	logic              out_valid_q;
	logic [SUM_W-1:0]  window_sum_q;
	qstat_t            query_status_q;

	logic [ECW-1:0]    eff_cols;
	logic [ERW-1:0]    eff_rows;
	logic              grid_zero, pos_rst, load_skip, col_last, row_last;
	logic [CW-1:0]     pos_col;
	logic [RW-1:0]     pos_row;

	logic signed [CRD-1:0] cols_s, rows_s, cl_c, ch_c, rl_c, rh_c;
	logic              win_empty, not_ready;
	qstat_t            qstat_d;

	logic [AW-1:0]     raddr_a, raddr_b, waddr;
	logic [SUM_W-1:0]  rdata_a, rdata_b, entry;

	// oversized register values count as the maximum
	assign eff_cols = (32'(grid_columns_q) > MAX_COLUMNS) ? ECW'(MAX_COLUMNS)
	                                                       : ECW'(grid_columns_q);
	assign eff_rows = (32'(grid_rows_q) > MAX_ROWS) ? ERW'(MAX_ROWS)
	                                                 : ERW'(grid_rows_q);
	assign grid_zero = (eff_cols == '0) || (eff_rows == '0);

	// load position for this beat
	assign pos_rst   = new_grid || (ECW'(load_col_q) >= eff_cols)
	                            || (ERW'(load_row_q) >= eff_rows);
	assign pos_col   = pos_rst ? '0 : load_col_q;
	assign pos_row   = pos_rst ? '0 : load_row_q;
	assign load_skip = grid_zero || (!new_grid && complete_q);

	assign col_last = (ECW'(load_col_q) + ECW'(1)) >= eff_cols;
	assign row_last = (ERW'(load_row_q) + ERW'(1)) >= eff_rows;

	// window clamp
	assign cols_s = CRD'(eff_cols);
	assign rows_s = CRD'(eff_rows);
	assign cl_c   = (col_low < 0) ? '0 : CRD'(col_low);
	assign rl_c   = (row_low < 0) ? '0 : CRD'(row_low);
	assign ch_c   = (CRD'(col_high) >= cols_s) ? cols_s - CRD'(1) : CRD'(col_high);
	assign rh_c   = (CRD'(row_high) >= rows_s) ? rows_s - CRD'(1) : CRD'(row_high);
	assign win_empty = (cl_c > ch_c) || (rl_c > rh_c);
	assign not_ready = !complete_q && !grid_zero;

	always_comb begin
		if (not_ready) begin
			qstat_d = QS_NOT_READY;
		end else if (win_empty) begin
			qstat_d = QS_EMPTY;
		end else begin
			qstat_d = QS_OK;
		end
	end

	// read addresses: entry above on a load, D/C on port A, B/A on port B
	always_comb begin
		if (cmd.rd_db) begin
			raddr_a = {rh_q, ch_q};
			raddr_b = {rl_q - RW'(1), ch_q};
		end else if (cmd.rd_ca) begin
			raddr_a = {rh_q, cl_q - CW'(1)};
			raddr_b = {rl_q - RW'(1), cl_q - CW'(1)};
		end else begin
			raddr_a = {pos_row - RW'(1), pos_col};
			raddr_b = {rl_q - RW'(1), cl_q - CW'(1)};
		end
	end

	assign waddr = {load_row_q, load_col_q};
	assign entry = rsum_q + ((load_row_q == '0) ? '0 : rdata_a);

	sat_ram #(
		.WIDTH (SUM_W),
		.DEPTH (2 ** AW)
	) u_table (
		.clk     (clk),
		.we      (cmd.ld_write),
		.waddr   (waddr),
		.wdata   (entry),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	// grid registers and load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= '0;
			grid_rows_q    <= '0;
			rsum_q         <= '0;
			load_col_q     <= '0;
			load_row_q     <= '0;
			complete_q     <= 1'b0;
		end else if (cfg_wr) begin
			if (cfg_sel == REG_GRID_ROWS) begin
				grid_rows_q <= cfg_wdata;
			end else begin
				grid_columns_q <= cfg_wdata;
			end
			rsum_q     <= '0;
			load_col_q <= '0;
			load_row_q <= '0;
			complete_q <= 1'b0;
		end else if (cmd.accept && operation == OP_LOAD && !load_skip) begin
			rsum_q     <= ((pos_col == '0) ? '0 : rsum_q) + SUM_W'(sample_value);
			load_col_q <= pos_col;
			load_row_q <= pos_row;
			if (new_grid) begin
				complete_q <= 1'b0;
			end
		end else if (cmd.ld_write) begin
			if (col_last) begin
				load_col_q <= '0;
				if (row_last) begin
					load_row_q <= '0;
					complete_q <= 1'b1;
				end else begin
					load_row_q <= load_row_q + RW'(1);
				end
			end else begin
				load_col_q <= load_col_q + CW'(1);
			end
		end
	end

	// query working registers
	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_QUERY) begin
			cl_q    <= cl_c[CW-1:0];
			ch_q    <= ch_c[CW-1:0];
			rl_q    <= rl_c[RW-1:0];
			rh_q    <= rh_c[RW-1:0];
			qstat_q <= qstat_d;
		end
		if (cmd.rd_ca) begin
			db_q <= rdata_a - ((rl_q == '0) ? '0 : rdata_b);
		end
		if (cmd.cap_ac) begin
			ac_q <= (((rl_q == '0) || (cl_q == '0)) ? '0 : rdata_b)
			      - ((cl_q == '0) ? '0 : rdata_a);
		end
		if (cmd.out_load) begin
			window_sum_q   <= (qstat_q == QS_OK) ? db_q + ac_q : '0;
			query_status_q <= qstat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.load_skip = load_skip;
	assign sts.qstat_ok  = (qstat_q == QS_OK);
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid    = out_valid_q;
	assign window_sum   = window_sum_q;
	assign query_status = query_status_q;
	assign cfg_rdata    = (cfg_sel == REG_GRID_ROWS) ? grid_rows_q : grid_columns_q;

	// the table is only marked complete by the write of its last entry
	a_complete_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(complete_q) |-> $past(cmd.ld_write))
		else $error("table complete without a table write");

	// empty and not-ready answers carry a zero sum
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && query_status_q != QS_OK) |-> window_sum_q == '0)
		else $error("nonzero sum on empty or not-ready answer");

endmodule

/* src/summed_area_table_build_query.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed_area_table_build_query: integral image build and rectangle sums
// Top level: APB register decode, controller and datapath.
// ----------------------------------------------------------------------------
// Samples are loaded in row-major order (operation 0, new_grid 1 on cell 0,0)
// and each is stored as its row's running sum plus the entry above it, so
// entry (r,c) holds the sum of rows 0..r and columns 0..c in 36-bit signed
// fixed point with 8 fraction bits. A query beat (operation 1) clamps its
// inclusive window to the grid and returns D - B - C + A, with status 0 ok,
// 1 empty window, 2 table not yet complete (sum 0 on both non-ok codes).
// One beat is taken at a time. In a load the entry above is read, then the
// new entry is written. An ignored load (zero-sized grid, or no new_grid
// once complete) writes nothing. A query reaches the output register through
// the clamp, two reads on the two read ports of the table RAM for the four
// corners (D - B is taken while the second pair is read), A - C, and the
// final add; not-ready and empty queries skip the corner reads.
// The output register holds a result while out_stall is high, and the input
// side only waits on it when a second query result is ready. Registers:
// grid_columns at 0x0 and grid_rows at 0x4 (7 bits, values above the
// maximum count as the maximum); writing either restarts the load and marks
// the table incomplete. No clear pass is needed after reset; the table is
// only queried once fully loaded.
// ----------------------------------------------------------------------------
module summed_area_table_build_query
	import sat_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input beat
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic                       new_grid,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic signed [COORD_W-1:0]  col_low,
	input  logic signed [COORD_W-1:0]  col_high,
	input  logic signed [COORD_W-1:0]  row_low,
	input  logic signed [COORD_W-1:0]  row_high,
	// result beat
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SUM_W-1:0]    window_sum,
	output logic [1:0]                 query_status,
	// APB register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_ADDR_W-1:0]      paddr,
	input  logic [APB_DATA_W-1:0]      pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	cmd_t              cmd;
	sts_t              sts;
	logic              cfg_wr;
	logic [GRID_W-1:0] cfg_rdata;

	// zero wait states; word address bit picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = APB_DATA_W'(cfg_rdata);

	sat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sat_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.new_grid     (new_grid),
		.sample_value (sample_value),
		.col_low      (col_low),
		.col_high     (col_high),
		.row_low      (row_low),
		.row_high     (row_high),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_sum   (window_sum),
		.query_status (query_status),
		.cfg_wr       (cfg_wr),
		.cfg_sel      (paddr[2]),
		.cfg_wdata    (pwdata[GRID_W-1:0]),
		.cfg_rdata    (cfg_rdata)
	);

endmodule
